/* rtl/core/qte_pkg.sv */
// Shared types, widths and the CORDIC angle table for the quaternion to Euler block.
// No dependencies; every other file in rtl/core imports this package.
package qte_pkg;

  localparam int QIW      = 16;  // quaternion component width
  localparam int PW       = 32;  // product of two components
  localparam int NW       = 35;  // atan2 operand width (units of 2^-30)
  localparam int SW       = 32;  // clamped asin argument
  localparam int QW       = 62;  // square root work width
  localparam int CW       = 48;  // CORDIC x/y width
  localparam int AW       = 26;  // angle accumulator, units of 2^-16 degree
  localparam int DW       = 9;   // whole degrees
  localparam int YW       = 8;   // yaw output width
  localparam int FRAC     = 16;
  localparam int PRE_SH   = 8;   // operand prescale by 256
  localparam int ATAN_LEN = 24;
  localparam int SQ_CELLS = 31;  // one result bit per cell
  localparam int SQ_TOP   = 60;  // first trial bit position

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 spec;
    logic signed [DW-1:0] sdeg;
  } cordic_t;

  typedef struct packed {
    logic [QW-1:0]        n;
    logic [QW-1:0]        r;
    logic signed [SW-1:0] s;
  } sqrt_t;

  // atan(2^-i) in degrees scaled by 65536, rounded to nearest
  function automatic logic signed [AW-1:0] atan_tab(input int unsigned i);
    logic signed [AW-1:0] v;
    case (i)
      0:  v = AW'(2949120);
      1:  v = AW'(1740967);
      2:  v = AW'(919879);
      3:  v = AW'(466945);
      4:  v = AW'(234379);
      5:  v = AW'(117304);
      6:  v = AW'(58666);
      7:  v = AW'(29335);
      8:  v = AW'(14668);
      9:  v = AW'(7334);
      10: v = AW'(3667);
      11: v = AW'(1833);
      12: v = AW'(917);
      13: v = AW'(458);
      14: v = AW'(229);
      15: v = AW'(115);
      16: v = AW'(57);
      17: v = AW'(29);
      18: v = AW'(14);
      19: v = AW'(7);
      20: v = AW'(4);
      21: v = AW'(2);
      22: v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/qte_sqrt_cell.sv */
// One digit cell of the pipelined integer square root: settles one result bit.
// Depends on qte_pkg (sqrt_t, QW).
module qte_sqrt_cell #(
  parameter int BITPOS = 60
) (
  input  logic          clk,
  input  logic          en,
  input  qte_pkg::sqrt_t d,
  output qte_pkg::sqrt_t q
);
  import qte_pkg::*;

  localparam logic [QW-1:0] TRIAL_BIT = QW'(1) << BITPOS;

  logic [QW-1:0] trial;
  sqrt_t         q_next;

  always_comb begin
    trial    = d.r + TRIAL_BIT;
    q_next   = d;
    if (d.n >= trial) begin
      q_next.n = d.n - trial;
      q_next.r = (d.r >> 1) + TRIAL_BIT;
    end else begin
      q_next.r = d.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* rtl/core/qte_cordic_cell.sv */
// One micro-rotation cell of a vectoring CORDIC, registered.
// Depends on qte_pkg (cordic_t, atan_tab).
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::cordic_t d,
  output qte_pkg::cordic_t q
);
  import qte_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cordic_t              q_next;

  always_comb begin
    xs     = $signed(d.x) >>> STEP;
    ys     = $signed(d.y) >>> STEP;
    q_next = d;
    if (!d.y[CW-1]) begin
      q_next.x   = d.x + ys;
      q_next.y   = d.y - xs;
      q_next.ang = d.ang + atan_tab(STEP);
    end else begin
      q_next.x   = d.x - ys;
      q_next.y   = d.y + xs;
      q_next.ang = d.ang - atan_tab(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

/* rtl/core/qte_atan_lane.sv */
// atan2 lane: axis checks and quadrant pre-rotation, a row of CORDIC cells,
// then truncation to whole degrees. Depends on qte_pkg and qte_cordic_cell.
module qte_atan_lane #(
  parameter int STEPS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [qte_pkg::NW-1:0] num,
  input  logic signed [qte_pkg::NW-1:0] den,
  output logic signed [qte_pkg::DW-1:0] deg
);
  import qte_pkg::*;

  localparam int NSTEP = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

  cordic_t              pre_next;
  cordic_t              chain [0:NSTEP];
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic signed [AW-1:0] ang;
  logic        [AW-1:0] mag;
  logic signed [AW-1:0] tdeg;
  logic signed [DW-1:0] deg_next;

  always_comb begin
    x0       = CW'(den) <<< PRE_SH;
    y0       = CW'(num) <<< PRE_SH;
    pre_next = '{x: x0, y: y0, ang: '0, spec: 1'b0, sdeg: '0};
    if (x0[CW-1]) begin
      if (!y0[CW-1]) begin
        pre_next.x   = y0;
        pre_next.y   = -x0;
        pre_next.ang = AW'(90 << FRAC);
      end else begin
        pre_next.x   = -y0;
        pre_next.y   = x0;
        pre_next.ang = -AW'(90 << FRAC);
      end
    end
    if (num == '0) begin
      pre_next.spec = 1'b1;
      pre_next.sdeg = den[NW-1] ? DW'(180) : DW'(0);
    end else if (den == '0) begin
      pre_next.spec = 1'b1;
      pre_next.sdeg = num[NW-1] ? -DW'(90) : DW'(90);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= pre_next;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    qte_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk),
      .en (en),
      .d  (chain[i]),
      .q  (chain[i+1])
    );
  end

  // truncate toward zero, then clamp to a half turn
  always_comb begin
    ang  = chain[NSTEP].ang;
    mag  = ang[AW-1] ? AW'(-ang) : AW'(ang);
    tdeg = ang[AW-1] ? -$signed(mag >> FRAC) : $signed(mag >> FRAC);
    if (tdeg > AW'(180)) begin
      deg_next = DW'(180);
    end else if (tdeg < -AW'(180)) begin
      deg_next = -DW'(180);
    end else begin
      deg_next = tdeg[DW-1:0];
    end
    if (chain[NSTEP].spec) begin
      deg_next = chain[NSTEP].sdeg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg <= deg_next;
    end
  end

endmodule

/* rtl/core/quaternion_to_euler_degrees_top.sv */
// Quaternion (Q1.15) to pitch/yaw/roll in whole degrees, fully pipelined.
// The yaw path, through the 31-cell square root and the yaw CORDIC row, is the
// longest; throughput one beat per cycle while the output skid register is empty.
// A one-beat output skid register parks a stalled beat; the chain freezes while full.
// Reset (rst, synchronous) clears stage valids and the skid; data needs none.
// Depends on qte_pkg, qte_sqrt_cell, qte_cordic_cell, qte_atan_lane.
module quaternion_to_euler_degrees_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [qte_pkg::QIW-1:0] quat_w,
  input  logic signed [qte_pkg::QIW-1:0] quat_x,
  input  logic signed [qte_pkg::QIW-1:0] quat_y,
  input  logic signed [qte_pkg::QIW-1:0] quat_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [qte_pkg::DW-1:0]  pitch_deg,
  output logic signed [qte_pkg::YW-1:0]  yaw_deg,
  output logic signed [qte_pkg::DW-1:0]  roll_deg
);
  import qte_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int LANE  = NSTEP + 2;
  localparam int DLY   = 2 + SQ_CELLS;
  localparam int DEPTH = 5 + SQ_CELLS + LANE;

  logic                 en;
  logic [DEPTH-1:0]     vld;

  logic signed [QIW-1:0] qw, qx, qy, qz;
  logic signed [PW-1:0]  ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  logic signed [NW-1:0]  pnum, pden, rnum, rden;
  logic signed [NW-1:0]  pnum_next, pden_next, rnum_next, rden_next, s_raw;
  logic signed [SW-1:0]  s2, s_next;
  logic signed [2*SW-1:0] s_sq;
  sqrt_t                 sq3, sq4, sq4_next;
  sqrt_t                 sq [0:SQ_CELLS];

  logic signed [DW-1:0]  pitch_lane, roll_lane, yaw_lane;
  logic signed [DW-1:0]  pitch_dl [0:DLY-1];
  logic signed [DW-1:0]  roll_dl  [0:DLY-1];
  logic signed [YW-1:0]  yaw_last;
  logic signed [NW-1:0]  yaw_den;

  logic                  skid_valid;
  logic signed [DW-1:0]  skid_pitch, skid_roll;
  logic signed [YW-1:0]  skid_yaw;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw <= quat_w;
      qx <= quat_x;
      qy <= quat_y;
      qz <= quat_z;
      ww <= qw * qw;
      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      wx <= qw * qx;
      wy <= qw * qy;
      wz <= qw * qz;
      xy <= qx * qy;
      xz <= qx * qz;
      yz <= qy * qz;
    end
  end

  always_comb begin
    pnum_next = (NW'(yz) + NW'(wx)) <<< 1;
    pden_next = NW'(ww) - NW'(xx) - NW'(yy) + NW'(zz);
    rnum_next = (NW'(xy) + NW'(wz)) <<< 1;
    rden_next = NW'(ww) + NW'(xx) - NW'(yy) - NW'(zz);
    s_raw     = (NW'(wy) - NW'(xz)) <<< 1;
    // clamp the asin argument to +-1.0
    if (s_raw > (NW'(1) <<< 30)) begin
      s_next = SW'(1) <<< 30;
    end else if (s_raw < -(NW'(1) <<< 30)) begin
      s_next = -(SW'(1) <<< 30);
    end else begin
      s_next = s_raw[SW-1:0];
    end
  end

  // full-width square of the clamped argument, up to 2^60
  assign s_sq = s2 * s2;

  always_ff @(posedge clk) begin
    if (en) begin
      pnum <= pnum_next;
      pden <= pden_next;
      rnum <= rnum_next;
      rden <= rden_next;
      s2   <= s_next;
      sq3  <= '{n: s_sq[QW-1:0], r: '0, s: s2};
      sq4  <= sq4_next;
    end
  end

  always_comb begin
    sq4_next   = sq3;
    sq4_next.n = (QW'(1) << SQ_TOP) - sq3.n;
  end

  assign sq[0] = sq4;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    qte_sqrt_cell #(.BITPOS(SQ_TOP - 2 * k)) u_sqrt (
      .clk(clk),
      .en (en),
      .d  (sq[k]),
      .q  (sq[k+1])
    );
  end

  qte_atan_lane #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en), .num(pnum), .den(pden), .deg(pitch_lane)
  );

  qte_atan_lane #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .num(rnum), .den(rden), .deg(roll_lane)
  );

  assign yaw_den = NW'($signed({1'b0, sq[SQ_CELLS].r[30:0]}));

  qte_atan_lane #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .num(NW'(sq[SQ_CELLS].s)), .den(yaw_den), .deg(yaw_lane)
  );

  // hold pitch and roll until yaw clears the square root
  always_ff @(posedge clk) begin
    if (en) begin
      pitch_dl[0] <= pitch_lane;
      roll_dl[0]  <= roll_lane;
      for (int i = 1; i < DLY; i++) begin
        pitch_dl[i] <= pitch_dl[i-1];
        roll_dl[i]  <= roll_dl[i-1];
      end
    end
  end

  always_comb begin
    if (yaw_lane > DW'(90)) begin
      yaw_last = YW'(90);
    end else if (yaw_lane < -DW'(90)) begin
      yaw_last = -YW'(90);
    end else begin
      yaw_last = yaw_lane[YW-1:0];
    end
  end

  // park the tail beat when the output stalls, so the chain can take one more
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[DEPTH-1] && out_stall) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && vld[DEPTH-1] && out_stall) begin
      skid_pitch <= pitch_dl[DLY-1];
      skid_yaw   <= yaw_last;
      skid_roll  <= roll_dl[DLY-1];
    end
  end

  assign out_valid = skid_valid || vld[DEPTH-1];
  assign pitch_deg = skid_valid ? skid_pitch : pitch_dl[DLY-1];
  assign yaw_deg   = skid_valid ? skid_yaw   : yaw_last;
  assign roll_deg  = skid_valid ? skid_roll  : roll_dl[DLY-1];

`ifndef SYNTHESIS
  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_stall) && $past(vld[DEPTH-1]))
    else $error("skid loaded without a stalled tail beat");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid && $stable(skid_yaw) && $stable(skid_pitch))
    else $error("skid beat lost under stall");

  a_chain_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(vld))
    else $error("chain advanced while skid full");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> yaw_deg >= -YW'(90) && yaw_deg <= YW'(90))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pitch_deg >= -DW'(180) && pitch_deg <= DW'(180))
    else $error("pitch out of range");
`endif

endmodule

/* verif/quaternion_to_euler_degrees_checker.sv */
// Checker for quaternion_to_euler_degrees_top: watches both channels, predicts
// pitch/yaw/roll for each accepted quaternion and compares results in order.
// Depends on qte_pkg for the port widths.
module quaternion_to_euler_degrees_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [qte_pkg::QIW-1:0] quat_w,
  input  logic signed [qte_pkg::QIW-1:0] quat_x,
  input  logic signed [qte_pkg::QIW-1:0] quat_y,
  input  logic signed [qte_pkg::QIW-1:0] quat_z,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [qte_pkg::DW-1:0]  pitch_deg,
  input  logic signed [qte_pkg::YW-1:0]  yaw_deg,
  input  logic signed [qte_pkg::DW-1:0]  roll_deg,
  output int                             errors,
  output int                             pending,
  output int                             checked
);
  import qte_pkg::*;

  typedef struct packed {
    logic signed [DW-1:0] pitch;
    logic signed [YW-1:0] yaw;
    logic signed [DW-1:0] roll;
  } euler_t;

  euler_t angles_due[$];

  localparam longint ATAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan2 in whole degrees, truncated toward zero
  function automatic longint atan2_degrees(longint num, longint den);
    longint cx, cy, ang, t, xs, ys, d;
    ang = 0;
    if (num == 0) return (den < 0) ? 180 : 0;
    if (den == 0) return (num > 0) ? 90 : -90;
    cx = den * 256;
    cy = num * 256;
    if (cx < 0) begin
      t = cx;
      if (cy >= 0) begin
        cx = cy;
        cy = -t;
        ang = 90 * 65536;
      end else begin
        cx = -cy;
        cy = t;
        ang = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx = cx + ys;
        cy = cy - xs;
        ang = ang + ATAN_DEG[i];
      end else begin
        cx = cx - ys;
        cy = cy + xs;
        ang = ang - ATAN_DEG[i];
      end
    end
    d = (ang >= 0) ? (ang >>> 16) : -((-ang) >>> 16);
    if (d > 180) d = 180;
    if (d < -180) d = -180;
    return d;
  endfunction

  function automatic euler_t quat_to_euler(longint w, longint x, longint y, longint z);
    euler_t e;
    longint s, yw;
    longint one;
    one = 64'sd1 <<< 30;
    e.pitch = DW'(atan2_degrees(2 * (y * z + w * x), w * w - x * x - y * y + z * z));
    e.roll  = DW'(atan2_degrees(2 * (x * y + w * z), w * w + x * x - y * y - z * z));
    s = 2 * (w * y - x * z);
    if (s > one) s = one;
    if (s < -one) s = -one;
    yw = atan2_degrees(s, longint'(int_sqrt(longint'(one * one - s * s))));
    if (yw > 90) yw = 90;
    if (yw < -90) yw = -90;
    e.yaw = YW'(yw);
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on beat %0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    checked = 0;
  end

  assign pending = angles_due.size();

  always @(posedge clk) begin
    euler_t e;
    if (!rst) begin
      if (in_valid && !in_stall)
        angles_due.push_back(quat_to_euler(quat_w, quat_x, quat_y, quat_z));
      if (out_valid && !out_stall) begin
        if (angles_due.size() == 0) begin
          $display("result beat with nothing expected: %0d %0d %0d",
                   pitch_deg, yaw_deg, roll_deg);
          errors++;
        end else begin
          e = angles_due.pop_front();
          if (pitch_deg !== e.pitch) report_mismatch("pitch", pitch_deg, e.pitch);
          if (yaw_deg !== e.yaw) report_mismatch("yaw", yaw_deg, e.yaw);
          if (roll_deg !== e.roll) report_mismatch("roll", roll_deg, e.roll);
        end
        checked++;
      end
    end
  end
endmodule

/* verif/quaternion_to_euler_degrees_top_test.sv */
// Testbench top for quaternion_to_euler_degrees_top: drives quaternions with random
// gaps and output stalls, and judges by the checker's error and pending counts.
// Depends on qte_pkg, the block and quaternion_to_euler_degrees_checker.
module quaternion_to_euler_degrees_top_test;
  import qte_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [QIW-1:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [DW-1:0] pitch_deg, roll_deg;
  logic signed [YW-1:0] yaw_deg;
  int errors, pending, checked;
  int sent = 0;
  int rx_cycle = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  quaternion_to_euler_degrees_top dut (.*);
  quaternion_to_euler_degrees_checker chk (.*);

  // Put one quaternion on the input and hold it until accepted.
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (!(sent >= 250 && sent < 340) && $urandom_range(99) < 31) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    quat_w <= w;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic [15:0] pick_component(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(512)) - 256);
      default: return ($urandom_range(1)) ? 16'h8000 + 16'($urandom_range(64))
                                          : 16'h7FFF - 16'($urandom_range(64));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off, one stretch with none
  always @(posedge clk) begin
    if (!rst) rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 300 && rx_cycle < 600) out_stall <= 1;
    else if (rx_cycle >= 900 && rx_cycle < 1100) out_stall <= 0;
    else out_stall <= ($urandom_range(99) < 31);
  end

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("FAIL quaternion_to_euler_degrees_top");
    $finish;
  end

  initial begin
    int mode;
    repeat (10) @(posedge clk);
    rst <= 0;
    // directed: zero, identity, axes, extremes, yaw saturation, negative denominators
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
    send_quat(16'h7FFF, 16'h0000, 16'h8000, 16'h0000);
    send_quat(16'h5A82, 16'h5A82, 16'h0000, 16'h0000);
    send_quat(16'h5A82, 16'hA57E, 16'h0000, 16'h0000);
    send_quat(16'h5A82, 16'h0000, 16'h0000, 16'h5A82);
    send_quat(16'h5A82, 16'h0000, 16'h0000, 16'hA57E);
    send_quat(16'h2000, 16'h7000, 16'h0000, 16'h0000);
    send_quat(16'h2000, 16'h9000, 16'h0000, 16'h0000);
    send_quat(16'h2000, 16'h0000, 16'h0000, 16'h9000);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
    send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000);
    send_quat(16'h4000, 16'hC000, 16'h4000, 16'hC000);
    for (int n = 0; n < 450; n++) begin
      mode = $urandom_range(9);
      mode = (mode < 6) ? 0 : (mode < 8) ? 1 : 2;
      send_quat(pick_component(mode), pick_component(mode),
                pick_component(mode), pick_component(mode));
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("sent %0d quaternions (directed axes and extremes, then random), checked %0d",
             sent, checked);
    $display("results under random gaps, a long output hold-off and a gap-free stretch");
    if (errors == 0 && pending == 0) begin
      $display("PASS quaternion_to_euler_degrees_top");
    end else begin
      $display("FAIL quaternion_to_euler_degrees_top");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/qte_pkg.sv
rtl/core/qte_sqrt_cell.sv
rtl/core/qte_cordic_cell.sv
rtl/core/qte_atan_lane.sv
rtl/core/quaternion_to_euler_degrees_top.sv
verif/quaternion_to_euler_degrees_checker.sv
verif/quaternion_to_euler_degrees_top_test.sv
